>>> rtl/lrq_pkg.sv
// ----------------------------------------------------------------------------
// lrq_pkg
// Shared types and constants for the Lamport request queue.
// ----------------------------------------------------------------------------
package lrq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 15;

    // Fixed field widths
    localparam int ID_W   = 4;
    localparam int TIME_W = 15;
    localparam int STAT_W = 2;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    localparam logic MODE_PUSH    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/lrq_ctrl.sv
// ----------------------------------------------------------------------------
// lrq_ctrl
// Sequencer: accept a transaction, run the table scan, hand off the result.
// ----------------------------------------------------------------------------
module lrq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lrq_pkg::dp_stat_t stat,
    output lrq_pkg::dp_cmd_t  cmd
);
    import lrq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
            end
            ST_OUT: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/lrq_datapath.sv
// ----------------------------------------------------------------------------
// lrq_datapath
// Request memory, release compaction, head search and output register.
// ----------------------------------------------------------------------------
module lrq_datapath #(
    parameter int DEPTH     = lrq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = lrq_pkg::TIME_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lrq_pkg::dp_cmd_t          cmd,
    output lrq_pkg::dp_stat_t         stat,
    input  logic                      s_mode,
    input  logic [lrq_pkg::ID_W-1:0]  s_process_id,
    input  logic [lrq_pkg::TIME_W-1:0] s_request_time,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [lrq_pkg::ID_W-1:0]  m_head_id,
    output logic [lrq_pkg::TIME_W-1:0] m_head_time,
    output logic                      m_queue_empty,
    output logic [lrq_pkg::STAT_W-1:0] m_status
);
    import lrq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int ENT_W = TIME_BITS + ID_W;

    // entry = {owner, time}
    logic [ENT_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     scan_len_reg;
    logic [CNT_W-1:0]     issue_ptr_reg;
    logic                 mode_reg;
    logic [ID_W-1:0]      pid_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [ENT_W-1:0]     rd_entry_reg;
    logic                 found_reg;
    logic                 best_valid_reg;
    logic [TIME_BITS-1:0] best_time_reg;
    logic [ID_W-1:0]      best_id_reg;
    status_t              status_reg;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [TIME_W-1:0]    out_time_reg;
    logic                 out_empty_reg;
    status_t              out_status_reg;

    logic                 full;
    logic [TIME_BITS-1:0] time_in;
    logic                 issue;
    logic [IDX_W-1:0]     rd_addr;
    logic [ID_W-1:0]      rd_owner;
    logic [TIME_BITS-1:0] rd_time;
    logic                 victim;
    logic                 take;
    logic                 better;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENT_W-1:0]     wr_data;
    logic                 push_ok;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign time_in  = TIME_BITS'(s_request_time);
    assign push_ok  = cmd.load && (s_mode == MODE_PUSH) && !full;
    assign issue    = cmd.step && (issue_ptr_reg != scan_len_reg);
    assign rd_addr  = issue_ptr_reg[IDX_W-1:0];
    assign rd_owner = rd_entry_reg[ENT_W-1 -: ID_W];
    assign rd_time  = rd_entry_reg[TIME_BITS-1:0];

    // first entry of the released id drops out; all later entries shift down
    assign victim = rd_valid_reg && (mode_reg == MODE_RELEASE) && !found_reg
                    && (rd_owner == pid_reg);
    assign take   = rd_valid_reg && !victim;
    assign better = !best_valid_reg
                    || ({rd_time, rd_owner} < {best_time_reg, best_id_reg});

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = {s_process_id, time_in};
        if (push_ok) begin
            wr_en = 1'b1;
        end else if (take && found_reg) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg - IDX_W'(1);
            wr_data = rd_entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            scan_len_reg  <= '0;
            issue_ptr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            if (cmd.load) begin
                issue_ptr_reg <= '0;
                found_reg     <= 1'b0;
                scan_len_reg  <= count_reg;
                if (push_ok) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end else begin
                if (issue) begin
                    issue_ptr_reg <= issue_ptr_reg + CNT_W'(1);
                end
                if (victim) begin
                    found_reg <= 1'b1;
                end
                if (cmd.commit && found_reg) begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    // item and running head
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg      <= s_mode;
            pid_reg       <= s_process_id;
            best_time_reg <= time_in;
            best_id_reg   <= s_process_id;
            if (s_mode == MODE_PUSH) begin
                best_valid_reg <= !full;
                status_reg     <= full ? STAT_FULL : STAT_DONE;
            end else begin
                best_valid_reg <= 1'b0;
                status_reg     <= STAT_DONE;
            end
        end else if (take && better) begin
            best_valid_reg <= 1'b1;
            best_time_reg  <= rd_time;
            best_id_reg    <= rd_owner;
        end
        if (issue) begin
            rd_idx_reg <= rd_addr;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_empty_reg  <= !best_valid_reg;
            out_id_reg     <= best_valid_reg ? best_id_reg : '0;
            out_time_reg   <= best_valid_reg ? TIME_W'(best_time_reg) : '0;
            out_status_reg <= ((mode_reg == MODE_RELEASE) && !found_reg)
                              ? STAT_NOT_FOUND : status_reg;
        end
    end

    assign stat.scan_done = (issue_ptr_reg == scan_len_reg) && !rd_valid_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign m_head_id     = out_id_reg;
    assign m_head_time   = out_time_reg;
    assign m_queue_empty = out_empty_reg;
    assign m_status      = out_status_reg;

endmodule

>>> rtl/lamport_request_queue.sv
// ----------------------------------------------------------------------------
// lamport_request_queue
// Request table for Lamport mutual exclusion with head-of-queue report.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per request. s_tuser is the mode (push or
//     release), s_tdata carries process id and timestamp. A push appends the
//     request; a release drops the oldest entry held for that id.
//   m_ channel: exactly one result per input transaction: the head (least
//     timestamp, ties to the smaller id), an empty flag and a status code
//     (done, push dropped on full table, release id not found).
//   Timing: the n entries held before the item are swept once through the
//     single-read-port memory, one entry per cycle. A release compacts the
//     table during the same sweep.
//   One item is in work at a time; s_tready is high only while idle, so a
//     new transaction is taken only after the last result entered the output register.
//   The result sits in an output register; if the receiver stalls, the next
//     item is still accepted and swept, and the block holds in its hand-off
//     step until the register frees up.
//   Reset empties the table at once (count only, no clearing pass) and drops
//     any pending result.
// ----------------------------------------------------------------------------
module lamport_request_queue #(
    parameter int DEPTH     = lrq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = lrq_pkg::TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input transactions
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lrq_pkg::S_TDATA_W-1:0]  s_tdata,  // [3:0] process_id, [18:4] request_time
    input  logic [lrq_pkg::S_TUSER_W-1:0]  s_tuser,  // [0] mode
    // result transactions
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lrq_pkg::M_TDATA_W-1:0]  m_tdata,  // [3:0] head_id, [18:4] head_time
    output logic [lrq_pkg::M_TUSER_W-1:0]  m_tuser   // [0] queue_empty, [2:1] status
);
    import lrq_pkg::*;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [ID_W-1:0]      head_id;
    logic [TIME_W-1:0]    head_time;
    logic                 queue_empty;
    logic [STAT_W-1:0]    status;

    lrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_mode         (s_tuser[0]),
        .s_process_id   (s_tdata[ID_W-1:0]),
        .s_request_time (s_tdata[ID_W +: TIME_W]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_head_id      (head_id),
        .m_head_time    (head_time),
        .m_queue_empty  (queue_empty),
        .m_status       (status)
    );

    // pack result, pad to whole bytes
    assign m_tdata = {{(M_TDATA_W - ID_W - TIME_W){1'b0}}, head_time, head_id};
    assign m_tuser = {status, queue_empty};

    // empty table reports a zero head
    a_empty_zero_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[ID_W+TIME_W-1:0] == '0))
        else $error("empty result with nonzero head");

    // a dropped push means the table was full, so never empty
    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] == STAT_FULL)) |-> !m_tuser[0])
        else $error("full-table drop reported an empty table");

    // no second transaction while one is in work
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("input ready right after accept");

    // a committed result shows up on the output
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("commit without result valid");

endmodule
